/* hw/rtl/sorted_circle_table_hit_test_assert.svh */
// Assertion macros used by the circle table RTL.
`ifndef SORTED_CIRCLE_TABLE_HIT_TEST_ASSERT_SVH
`define SORTED_CIRCLE_TABLE_HIT_TEST_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication check.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/sct_pkg.sv */
// Package with the codes, types and default sizes of the circle table.
`default_nettype none
package sct_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;
  localparam int ID_W            = 6;

  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_QUERY      = 2'd1;
  localparam logic [1:0] ACT_QUERY_SKIP = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_HIT      = 2'd1;
  localparam logic [1:0] ST_NO_HIT   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_QRY
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/sorted_circle_table_hit_test.sv */
// Sorted circle table with point hit test, built around one entry memory.
`default_nettype none
`include "sorted_circle_table_hit_test_assert.svh"
// Insert: an empty table goes straight to placement. Otherwise each entry with a smaller
// radius is moved down one slot until one that is not smaller is met or the top is passed
// (one memory read a cycle while shifting). A full-table insert is refused without a scan.
// Query: the memory read port scans one entry a cycle into a distance pipeline and the
// first hit ends the scan. An empty table answers without a scan.
// One request at a time; done pulses for one cycle and the receiver cannot stall it.
// Synchronous reset empties the table (count to zero); memory contents are not cleared.
module sorted_circle_table_hit_test #(
  parameter int MAX_ENTRIES = sct_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = sct_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = sct_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              action,
  input  wire logic [COORD_BITS-1:0]   point_x,
  input  wire logic [COORD_BITS-1:0]   point_y,
  input  wire logic [RADIUS_BITS-1:0]  circle_radius,
  input  wire logic [sct_pkg::ID_W-1:0] excluded_id,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [sct_pkg::ID_W-1:0]     entry_id
);
  import sct_pkg::*;

  // Address and count widths. The count must be able to hold MAX_ENTRIES itself.
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  // One memory word holds a whole circle: {x, y, radius, id}.
  localparam int EW = 2 * COORD_BITS + RADIUS_BITS + ID_W;
  localparam int ID_LO = 0;
  localparam int R_LO  = ID_W;
  localparam int Y_LO  = ID_W + RADIUS_BITS;
  localparam int X_LO  = ID_W + RADIUS_BITS + COORD_BITS;
  // Widths of a squared coordinate difference and of a squared radius.
  localparam int DQW = 2 * COORD_BITS;
  localparam int RQW = 2 * RADIUS_BITS;
  // The squared-distance sum needs one bit more than a single square.
  localparam int SW = (2 * COORD_BITS + 1 > 2 * RADIUS_BITS) ?
                      2 * COORD_BITS + 1 : 2 * RADIUS_BITS;

  // Entry memory: one write port and one registered read port.
  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // Control state and captured request.
  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [AW-1:0]          rd_slot, rd_slot_next;
  logic [AW-1:0]          place_addr, place_addr_next;
  logic [COORD_BITS-1:0]  px, py;
  logic [RADIUS_BITS-1:0] rad;
  logic                   skip;
  logic [ID_W-1:0]        excl;
  logic                   load;

  logic                   done_next;
  logic [1:0]             status_next;
  logic [ID_W-1:0]        entry_id_next;

  // Query pipeline. Stage 1 is the memory read data itself.
  logic                   s1_valid, s1_valid_next;
  logic                   s1_last, s1_last_next;
  logic                   s2_valid, s2_last, s2_skip;
  logic [COORD_BITS-1:0]  s2_dx, s2_dy;
  logic [RADIUS_BITS-1:0] s2_r;
  logic [ID_W-1:0]        s2_id;
  logic                   s3_valid, s3_last, s3_skip;
  logic [2*COORD_BITS-1:0]  s3_dx2, s3_dy2;
  logic [2*RADIUS_BITS-1:0] s3_r2;
  logic [ID_W-1:0]        s3_id;
  logic                   flush;

  logic [COORD_BITS-1:0]  rd_x, rd_y;
  logic [RADIUS_BITS-1:0] rd_r;
  logic [ID_W-1:0]        rd_id;
  logic [ID_W-1:0]        new_id;
  logic [SW-1:0]          dist2;
  logic                   s3_hit;

  assign rd_x  = rd_data[X_LO +: COORD_BITS];
  assign rd_y  = rd_data[Y_LO +: COORD_BITS];
  assign rd_r  = rd_data[R_LO +: RADIUS_BITS];
  assign rd_id = rd_data[ID_LO +: ID_W];

  // Ids count up with the table size and wrap at the id width.
  assign new_id = ID_W'(count);

  assign dist2  = SW'(s3_dx2) + SW'(s3_dy2);
  assign s3_hit = s3_valid && !s3_skip && (dist2 < SW'(s3_r2));

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      if (flush) begin
        s1_valid <= 1'b0;
        s2_valid <= 1'b0;
        s3_valid <= 1'b0;
      end else begin
        s1_valid <= s1_valid_next;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    rd_slot    <= rd_slot_next;
    place_addr <= place_addr_next;
    status     <= status_next;
    entry_id   <= entry_id_next;
    s1_last    <= s1_last_next;
    if (load) begin
      px   <= point_x;
      py   <= point_y;
      rad  <= circle_radius;
      skip <= (action == ACT_QUERY_SKIP);
      excl <= excluded_id;
    end
    // Stage 2: absolute coordinate differences and the exclusion test.
    s2_last <= s1_last;
    s2_skip <= skip && (rd_id == excl);
    s2_dx   <= (px >= rd_x) ? px - rd_x : rd_x - px;
    s2_dy   <= (py >= rd_y) ? py - rd_y : rd_y - py;
    s2_r    <= rd_r;
    s2_id   <= rd_id;
    // Stage 3: the three squares, each on its own multiplier.
    s3_last <= s2_last;
    s3_skip <= s2_skip;
    s3_dx2  <= DQW'(s2_dx) * DQW'(s2_dx);
    s3_dy2  <= DQW'(s2_dy) * DQW'(s2_dy);
    s3_r2   <= RQW'(s2_r) * RQW'(s2_r);
    s3_id   <= s2_id;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_slot_next    = rd_slot;
    place_addr_next = place_addr;
    rd_addr         = rd_slot - AW'(1);
    wr_en           = 1'b0;
    wr_addr         = rd_slot + AW'(1);
    wr_data         = rd_data;
    done_next       = 1'b0;
    status_next     = status;
    entry_id_next   = entry_id;
    s1_valid_next   = 1'b0;
    s1_last_next    = s1_last;
    flush           = 1'b0;
    load            = 1'b0;

    unique case (state)
      S_IDLE: begin
        // Start every scan at the last valid entry.
        rd_addr = AW'(count - CW'(1));
        if (start) begin
          load = 1'b1;
          if (action == ACT_INSERT) begin
            if (count == CW'(MAX_ENTRIES)) begin
              done_next     = 1'b1;
              status_next   = ST_FULL;
              entry_id_next = '0;
            end else if (count == '0) begin
              place_addr_next = '0;
              state_next      = S_PLACE;
            end else begin
              rd_slot_next = AW'(count - CW'(1));
              state_next   = S_INS;
            end
          end else begin
            if (count == '0) begin
              done_next     = 1'b1;
              status_next   = ST_NO_HIT;
              entry_id_next = '0;
            end else begin
              rd_slot_next  = AW'(count - CW'(1));
              s1_valid_next = 1'b1;
              s1_last_next  = (count == CW'(1));
              state_next    = S_QRY;
            end
          end
        end
      end

      S_INS: begin
        // Walk up from the end, moving each smaller circle down one slot, until
        // an entry of equal or larger radius is met or the top is passed.
        rd_slot_next = rd_slot - AW'(1);
        if (rd_r < rad) begin
          wr_en = 1'b1;
          if (rd_slot == '0) begin
            place_addr_next = '0;
            state_next      = S_PLACE;
          end
        end else begin
          place_addr_next = rd_slot + AW'(1);
          state_next      = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_en         = 1'b1;
        wr_addr       = place_addr;
        wr_data       = {px, py, rad, new_id};
        count_next    = count + CW'(1);
        done_next     = 1'b1;
        status_next   = ST_INSERTED;
        entry_id_next = new_id;
        state_next    = S_IDLE;
      end

      S_QRY: begin
        // Keep issuing reads toward slot zero while the pipeline fills.
        if (s1_valid && !s1_last) begin
          s1_valid_next = 1'b1;
          s1_last_next  = (rd_slot == AW'(1));
          rd_slot_next  = rd_slot - AW'(1);
        end
        // The first hit out of the pipeline is the one nearest the end of the order.
        if (s3_hit) begin
          done_next     = 1'b1;
          status_next   = ST_HIT;
          entry_id_next = s3_id;
          flush         = 1'b1;
          state_next    = S_IDLE;
        end else if (s3_valid && s3_last) begin
          done_next     = 1'b1;
          status_next   = ST_NO_HIT;
          entry_id_next = '0;
          flush         = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The table never holds more circles than it has room for.
  `SCT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES))
  // A result always leaves the block ready for the next request.
  `SCT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  // Every accepted request either starts work or answers at once.
  `SCT_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  // An insert into a full table is refused on the next cycle.
  `SCT_ASSERT_NEXT(a_full_drop, clk, rst,
    start && !busy && action == ACT_INSERT && count == CW'(MAX_ENTRIES),
    done && status == ST_FULL)
  // The memory is only written while an insert is in progress.
  `SCT_ASSERT_IMP(a_write_in_insert, clk, rst, wr_en, state == S_INS || state == S_PLACE)

endmodule
`default_nettype wire
